/* hdl/bhbc_pkg.sv */
// shared constants, types and saturation helpers of the high-pass biquad cascade
`default_nettype none
package bhbc_pkg;

  localparam int MAX_SECTIONS  = 4;
  localparam int NUM_COEF_REGS = 4;
  localparam int SEC_W         = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SAMPLE_W      = 16;
  localparam int DATA_W        = 32;
  localparam int DATA_FRAC     = 8;
  localparam int COEF_W        = 20;
  localparam int COEF_FRAC     = 17;
  localparam int COEF_REG_W    = 3 * COEF_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CNT_W         = 4;
  localparam int PROD_W        = COEF_W + DATA_W;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SECTIONS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST       = 3'd4;

  typedef logic [COEF_REG_W-1:0] coef_word_t;
  typedef coef_word_t coef_bank_t [NUM_COEF_REGS];

  // status of the section engine as seen by the stream wrapper
  typedef struct packed {
    logic idle;
    logic done;
  } bhbc_stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = DATA_W'(hi);
    end else if (v < lo) begin
      sat32 = DATA_W'(lo);
    end else begin
      sat32 = DATA_W'(v);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd32767;
    lo = -64'sd32768;
    if (v > hi) begin
      sat16 = SAMPLE_W'(hi);
    end else if (v < lo) begin
      sat16 = SAMPLE_W'(lo);
    end else begin
      sat16 = SAMPLE_W'(v);
    end
  endfunction

endpackage
`default_nettype wire

/* hdl/bhbc_ram.sv */
// generic single-clock ram, one write port and one registered read port
`default_nettype none
module bhbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/bhbc_core.sv */
// section engine: sequencer, shared multiplier and delay-line memory
`default_nettype none
module bhbc_core
  import bhbc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic signed [SAMPLE_W-1:0]  sample,
  input  wire logic [2:0]                  active_sections,
  input  wire coef_bank_t                  coefs,
  input  wire logic                        res_ready,
  output bhbc_stat_t                       stat,
  output logic signed [SAMPLE_W-1:0]       result
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_READ = 9'b000000010,
    ST_MUL1 = 9'b000000100,
    ST_MUL2 = 9'b000001000,
    ST_SUM  = 9'b000010000,
    ST_DIFF = 9'b000100000,
    ST_GAIN = 9'b001000000,
    ST_NEXT = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [SEC_W-1:0]              sec;
  logic [SEC_W-1:0]              last_sec;
  logic [CNT_W-1:0]              n_eff;
  logic [MAX_SECTIONS-1:0]       written;
  logic                          rd_vld;
  logic [2*DATA_W-1:0]           rd_data;
  logic                          rd_en;
  logic [SEC_W-1:0]              rd_addr;
  logic                          wr_en;

  logic signed [DATA_W-1:0]      x;
  logic signed [DATA_W-1:0]      w0;
  logic signed [DATA_W-1:0]      w1;
  logic signed [DATA_W-1:0]      w2;
  logic signed [DATA_W-1:0]      diff;
  logic signed [DATA_W-1:0]      w1_rd;
  logic signed [DATA_W-1:0]      w2_rd;
  logic signed [PROD_W+1:0]      acc;
  logic signed [PROD_W-1:0]      prod;

  coef_word_t                    coef_sel;
  logic signed [COEF_W-1:0]      ga, c1, c2;
  logic signed [COEF_W-1:0]      mul_a;
  logic signed [DATA_W-1:0]      mul_b;

  logic signed [PROD_W+3:0]      w0_rnd;
  logic signed [DATA_W+2:0]      diff_sum;
  logic signed [PROD_W:0]        y_rnd;
  logic signed [DATA_W:0]        out_rnd;

  // clamp the section count to 1 .. MAX_SECTIONS
  always_comb begin
    n_eff = CNT_W'(active_sections);
    if (n_eff == '0) begin
      n_eff = CNT_W'(1);
    end else if (n_eff > CNT_W'(MAX_SECTIONS)) begin
      n_eff = CNT_W'(MAX_SECTIONS);
    end
    last_sec = SEC_W'(n_eff - CNT_W'(1));
  end

  // sections without a register see zero coefficients
  always_comb begin
    coef_sel = '0;
    for (int k = 0; k < NUM_COEF_REGS; k++) begin
      if ((SEC_W + 4)'(sec) == (SEC_W + 4)'(k)) begin
        coef_sel = coefs[k];
      end
    end
    ga = coef_sel[COEF_W-1:0];
    c1 = coef_sel[2*COEF_W-1:COEF_W];
    c2 = coef_sel[3*COEF_W-1:2*COEF_W];
  end

  // never-written entries read as zero
  assign w1_rd = rd_vld ? rd_data[DATA_W-1:0] : '0;
  assign w2_rd = rd_vld ? rd_data[2*DATA_W-1:DATA_W] : '0;

  always_comb begin
    mul_a = c1;
    mul_b = w1_rd;
    case (state)
      ST_MUL2: begin
        mul_a = c2;
        mul_b = w2;
      end
      ST_GAIN: begin
        mul_a = ga;
        mul_b = diff;
      end
      default: begin
        mul_a = c1;
        mul_b = w1_rd;
      end
    endcase
  end

  assign w0_rnd   = (PROD_W + 4)'(acc) + (PROD_W + 4)'(prod)
                    + (PROD_W + 4)'(64'sd1 <<< (COEF_FRAC - 1));
  assign diff_sum = (DATA_W + 3)'(w0) - ((DATA_W + 3)'(w1) <<< 1) + (DATA_W + 3)'(w2);
  assign y_rnd    = (PROD_W + 1)'(prod) + (PROD_W + 1)'(64'sd1 <<< (COEF_FRAC - 1));
  assign out_rnd  = (DATA_W + 1)'(x) + (DATA_W + 1)'(64'sd1 <<< (DATA_FRAC - 1));

  assign result = sat16(64'(out_rnd >>> DATA_FRAC));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_READ;
      ST_READ: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_GAIN;
      ST_GAIN: state_next = ST_NEXT;
      ST_NEXT: state_next = (sec == last_sec) ? ST_DONE : ST_MUL1;
      ST_DONE: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // read for section 0 at item start, next section prefetched while writing back
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == ST_READ) begin
      rd_en = 1'b1;
    end else if (state == ST_DIFF && sec != last_sec) begin
      rd_en   = 1'b1;
      rd_addr = sec + SEC_W'(1);
    end
  end

  assign wr_en = (state == ST_DIFF);

  bhbc_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_SECTIONS)
  ) u_delay_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sec),
    .wr_data ({w1, w0}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sec     <= '0;
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      state <= state_next;
      if (rd_en) begin
        rd_vld <= written[rd_addr];
      end
      if (wr_en) begin
        written[sec] <= 1'b1;
      end
      if (state == ST_IDLE) begin
        sec <= '0;
      end else if (state == ST_NEXT && sec != last_sec) begin
        sec <= sec + SEC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (start) x <= DATA_W'(sample) <<< DATA_FRAC;
      end
      ST_MUL1: begin
        w1 <= w1_rd;
        w2 <= w2_rd;
      end
      ST_MUL2: acc  <= ((PROD_W + 2)'(x) <<< COEF_FRAC) + (PROD_W + 2)'(prod);
      ST_SUM:  w0   <= sat32(64'(w0_rnd >>> COEF_FRAC));
      ST_DIFF: diff <= sat32(64'(diff_sum));
      ST_NEXT: x    <= sat32(64'(y_rnd >>> COEF_FRAC));
      default: begin
      end
    endcase
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

endmodule
`default_nettype wire

/* hdl/butterworth_highpass_biquad_cascade.sv */
// top level: stream ports, configuration registers and output register
`default_nettype none
// one sample in flight: a new input beat is taken only once the engine is back in idle;
//   the sample rate is set by the shared 20 x 32 multiplier, used three times per section,
//   by the delay-memory read-modify-write of each section and by output back-pressure
// reset: rst is synchronous, active high; it clears the delay lines (via per-entry
//   valid flags), the coefficients, and sets the section count to two
module butterworth_highpass_biquad_cascade
  import bhbc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SAMPLE_W-1:0]   s_tdata,     // [15:0] sample_in
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [SAMPLE_W-1:0]        m_tdata,     // [15:0] sample_out
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_REG_W-1:0] cfg_data
);

  logic [2:0]                 active_sections;
  coef_bank_t                 coefs;
  bhbc_stat_t                 stat;
  logic signed [SAMPLE_W-1:0] result;
  logic                       res_ready;
  logic                       start;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= 3'd2;
      for (int k = 0; k < NUM_COEF_REGS; k++) begin
        coefs[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ACTIVE_SECTIONS) begin
        active_sections <= cfg_data[2:0];
      end else if (cfg_index >= REG_COEF_FIRST && cfg_index <= REG_COEF_LAST) begin
        // writes beyond the last coefficient register fall through and do nothing
        coefs[2'(cfg_index - REG_COEF_FIRST)] <= cfg_data;
      end
    end
  end

  // the engine takes a new sample whenever it is idle, even while the
  // output register still holds the previous beat
  assign s_tready = stat.idle;
  assign start    = s_tvalid && s_tready;

  // the engine hands its result over once the output register is free
  assign res_ready = !m_tvalid || m_tready;

  bhbc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .sample          (s_tdata),
    .active_sections (active_sections),
    .coefs           (coefs),
    .res_ready       (res_ready),
    .stat            (stat),
    .result          (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.done && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && res_ready) begin
      m_tdata <= result;
    end
  end

  // one sample in flight: an accepted beat closes the input side
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while the engine was busy");

  // a result beat only appears after the engine finished
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.done))
    else $error("output beat without a finished sample");

  // a finished result waits while the output register is blocked
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    stat.done && m_tvalid && !m_tready |=> stat.done)
    else $error("finished result dropped while output stalled");

endmodule
`default_nettype wire
